[src/sorted_array_priority_queue_assert.svh]
// Assertion macros for the sorted array priority queue checker.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define SAPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SAPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sapq_pkg.sv]
// Shared types and constants of the sorted array priority queue.
package sapq_pkg;

	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_PEEK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_HEAD,
		ST_SHIFT,
		ST_FINISH
	} state_t;

endpackage

[src/sapq_if.sv]
// Request and response channel interfaces of the priority queue.
interface sapq_req_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             kind;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink (input valid, kind, value, output ready);
endinterface

interface sapq_rsp_if #(
	parameter int VALUE_WIDTH = 32,
	parameter int CNT_W       = 7
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] result_value;
	logic [1:0]             status;
	logic [CNT_W-1:0]       occupancy;

	modport source (output valid, result_value, status, occupancy, input ready);
	modport sink (input valid, result_value, status, occupancy, output ready);
endinterface

[src/sapq_ram.sv]
// Generic single write port RAM with registered read.
module sapq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/sapq_cmp.sv]
// Shared two's complement signed comparator used by the insert walk.
module sapq_cmp #(
	parameter int WIDTH = 32
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             gt
);

	assign gt = $signed(a) > $signed(b);

endmodule

[src/sorted_array_priority_queue.sv]
// Top level of the sorted array min priority queue.
//
// Channels: req (sink) carries kind and value; rsp (source) carries
// result_value, status and occupancy. A beat moves when valid and ready
// are both high. cfg_we/cfg_wdata write the capacity register; write it
// only while the queue is idle.
// Entries sit ascending in one RAM, smallest at address 0. One request is
// worked at a time, and req.ready is low until its result is staged; a new
// request is not taken before then.
// Work is bound by the single RAM port pair and the one shared comparator:
//   refused insert, empty remove/peek, unused kind: straight to finish
//   insert: each larger entry shifted up one slot (one per cycle)
//   peek: head read;  remove: head read, rest shifted down (one per cycle)
// The result lands in an output register; the next request is taken while
// it waits there. If the receiver stalls, a finished result holds in the
// sequencer until the output register frees up.
// Reset: count 0, capacity 64, no result pending. RAM contents are left
// undefined; only slots below the count are ever read.
module sorted_array_priority_queue
	import sapq_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	sapq_req_if.sink         req,
	sapq_rsp_if.source       rsp
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// control state
	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CAP_W-1:0]    cap_q;
	logic                rsp_valid_q, rsp_valid_d;

	// work registers
	kind_t               kind_q, kind_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [CNT_W-1:0]    pos_q, pos_d;
	logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
	status_t             res_stat_q, res_stat_d;

	// output register
	logic [VALUE_WIDTH-1:0] rsp_val_q;
	status_t             rsp_stat_q;
	logic [CNT_W-1:0]    rsp_occ_q;

	// RAM and comparator
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
	logic                   cmp_gt;

	logic                load_rsp;
	logic                full;
	logic [CNT_W-1:0]    pos_m1, pos_m2, pos_p1;

	sapq_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_sapq_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// does the stored entry sort after the new value?
	sapq_cmp #(
		.WIDTH(VALUE_WIDTH)
	) u_sapq_cmp (
		.a (ram_rdata),
		.b (val_q),
		.gt(cmp_gt)
	);

	// capacity above DEPTH saturates; count never exceeds DEPTH
	assign full = (count_q == CNT_W'(DEPTH)) || (CMP_W'(count_q) >= CMP_W'(cap_q));

	assign pos_m1 = pos_q - CNT_W'(1);
	assign pos_m2 = pos_q - CNT_W'(2);
	assign pos_p1 = pos_q + CNT_W'(1);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		kind_d     = kind_q;
		val_d      = val_q;
		pos_d      = pos_q;
		res_val_d  = res_val_q;
		res_stat_d = res_stat_q;
		ram_we     = 1'b0;
		ram_waddr  = pos_q[AW-1:0];
		ram_wdata  = val_q;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		req.ready  = 1'b0;
		load_rsp   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					kind_d     = kind_t'(req.kind);
					val_d      = req.value;
					res_val_d  = '0;
					res_stat_d = STAT_OK;
					state_d    = ST_FINISH;
					case (kind_t'(req.kind))
						KIND_INSERT: begin
							if (full) begin
								res_stat_d = STAT_FULL;
							end else begin
								pos_d   = count_q;
								state_d = ST_INS_RD;
							end
						end
						KIND_REMOVE, KIND_PEEK: begin
							if (count_q == '0) begin
								res_stat_d = STAT_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								state_d   = ST_HEAD;
							end
						end
						default: ;
					endcase
				end
			end

			// fetch the neighbor below the hole, or drop the value in at slot 0
			ST_INS_RD: begin
				if (pos_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = val_q;
					count_d   = count_q + CNT_W'(1);
					state_d   = ST_FINISH;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = pos_m1[AW-1:0];
					state_d   = ST_INS_CMP;
				end
			end

			// larger neighbor moves up one, next one prefetched in the same cycle; else the value fills the hole
			ST_INS_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				if (cmp_gt) begin
					ram_wdata = ram_rdata;
					pos_d     = pos_m1;
					if (pos_q > CNT_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = pos_m2[AW-1:0];
					end else begin
						state_d = ST_INS_RD;
					end
				end else begin
					ram_wdata = val_q;
					count_d   = count_q + CNT_W'(1);
					state_d   = ST_FINISH;
				end
			end

			// head entry is on the read port; a remove of more than one entry starts the shift down
			ST_HEAD: begin
				res_val_d = ram_rdata;
				state_d   = ST_FINISH;
				if (kind_q == KIND_REMOVE) begin
					if (count_q > CNT_W'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(1);
						pos_d     = CNT_W'(1);
						state_d   = ST_SHIFT;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end

			// slot pos moves down to pos-1, next slot prefetched
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_m1[AW-1:0];
				ram_wdata = ram_rdata;
				if (pos_p1 < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = pos_p1[AW-1:0];
					pos_d     = pos_p1;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_FINISH;
				end
			end

			// hand the result to the output register once it is free
			ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (load_rsp) begin
			rsp_valid_d = 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q     <= kind_d;
		val_q      <= val_d;
		pos_q      <= pos_d;
		res_val_q  <= res_val_d;
		res_stat_q <= res_stat_d;
		if (load_rsp) begin
			rsp_val_q  <= res_val_q;
			rsp_stat_q <= res_stat_q;
			rsp_occ_q  <= count_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_val_q;
	assign rsp.status       = rsp_stat_q;
	assign rsp.occupancy    = rsp_occ_q;

endmodule

[src/sapq_chk.sv]
// Port level checker for the priority queue, bound to the top level.
`include "sorted_array_priority_queue_assert.svh"

module sapq_chk
	import sapq_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int CNT_W       = 7
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [VALUE_WIDTH-1:0] rsp_result_value,
	input logic [1:0]             rsp_status,
	input logic [CNT_W-1:0]       rsp_occupancy
);

	`SAPQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_occupancy), "stalled response beat changed")
	`SAPQ_ASSERT(a_req_busy, clk, arst_n, req_valid && req_ready |=> !req_ready, "request taken while busy")
	`SAPQ_ASSERT(a_fail_zero, clk, arst_n, rsp_valid && rsp_status != STAT_OK |-> rsp_result_value == '0, "failed request returned a value")
	`SAPQ_ASSERT(a_empty_occ, clk, arst_n, rsp_valid && rsp_status == STAT_EMPTY |-> rsp_occupancy == '0, "empty status with entries held")
	`SAPQ_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !rsp_valid, "response valid during reset")

endmodule

bind sorted_array_priority_queue sapq_chk #(
	.VALUE_WIDTH(VALUE_WIDTH),
	.CNT_W      ($clog2(DEPTH + 1))
) u_sapq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_result_value(rsp.result_value),
	.rsp_status      (rsp.status),
	.rsp_occupancy   (rsp.occupancy)
);

[tb/pq_check.sv]
// Watches the queue channels, predicts each response and compares it.
module pq_check
	import sapq_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	sapq_req_if              req,
	sapq_rsp_if              rsp,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] result_value;
		status_t                status;
		logic [CAP_W-1:0]       occupancy;
	} pq_result_t;

	logic signed [VALUE_WIDTH-1:0] held [DEPTH];
	int unsigned      held_count;
	logic [CAP_W-1:0] capacity;
	pq_result_t       due_results [$];
	pq_result_t       want;
	int unsigned      rsp_beats;

	task automatic report(input string msg);
		$display("[%0t] rsp beat %0d: %s", $time, rsp_beats, msg);
		mismatches++;
	endtask

	// Applies one request to the shadow queue and returns its response.
	function automatic pq_result_t serve_request(input logic [1:0] kind,
			input logic signed [VALUE_WIDTH-1:0] value);
		pq_result_t  r;
		int unsigned limit;
		int          pos;
		r.result_value = '0;
		r.status       = STAT_OK;
		limit = (capacity > DEPTH) ? DEPTH : capacity;
		case (kind)
			KIND_INSERT: begin
				if (held_count >= limit) begin
					r.status = STAT_FULL;
				end else begin
					// new entry lands after all equal or smaller ones
					pos = held_count;
					while (pos > 0 && held[pos-1] > value) begin
						held[pos] = held[pos-1];
						pos--;
					end
					held[pos] = value;
					held_count++;
				end
			end
			KIND_REMOVE, KIND_PEEK: begin
				if (held_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.result_value = held[0];
					if (kind == KIND_REMOVE) begin
						for (int i = 1; i < held_count; i++)
							held[i-1] = held[i];
						held_count--;
					end
				end
			end
			default: ; // unused kind: no-op, count reported as is
		endcase
		r.occupancy = held_count[CAP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count  = 0;
			capacity    = CAP_RESET;
			mismatches  = 0;
			outstanding = 0;
			rsp_beats   = 0;
			due_results.delete();
		end else begin
			// response first: it can never belong to a request taken this edge
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					report($sformatf("response with nothing outstanding (value 0x%0h)",
						rsp.result_value));
				end else begin
					want = due_results.pop_front();
					if (rsp.result_value !== want.result_value)
						report($sformatf("result_value got 0x%0h expected 0x%0h",
							rsp.result_value, want.result_value));
					if (rsp.status !== want.status)
						report($sformatf("status got %0d expected %0d",
							rsp.status, want.status));
					if (rsp.occupancy !== want.occupancy)
						report($sformatf("occupancy got %0d expected %0d",
							rsp.occupancy, want.occupancy));
				end
				rsp_beats++;
			end
			if (req.valid && req.ready)
				due_results.push_back(serve_request(req.kind, req.value));
			if (cfg_we)
				capacity = cfg_wdata;
			outstanding = due_results.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Stimulus, clock, reset and verdict for the sorted array priority queue.
module tb_top;
	import sapq_pkg::*;

	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ITEMS       = 800;
	// the request code the block treats as a no-op
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	sapq_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
	sapq_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .CNT_W(CAP_W)) rsp_ch ();

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned n_sent;
	// random idling on both channels; cleared for quiet stretches and the tail
	bit          idle_en;

	sorted_array_priority_queue #(
		.DEPTH      (DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	pq_check #(
		.DEPTH      (DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset asserted at the start, released on a falling edge, never asserted again.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Response side: ready mostly high, dropped low in random bursts while idling is enabled.
	initial begin
		rsp_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// Hang guard: far beyond the slowest legal run (every remove at full depth,
	// every beat behind the longest stall on both sides).
	initial begin
		#1500000;
		$display("*** FAILED ***");
		$finish;
	end

	// One request beat. Entered and left at a falling edge; valid stays up
	// afterwards so back-to-back beats never glitch it.
	task automatic send(input logic [1:0] kind, input logic [VALUE_WIDTH-1:0] value);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.kind  = kind;
		req_ch.value = value;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		n_sent++;
	endtask

	// Stop sending and let every outstanding response come back. The block
	// works one request at a time, so an empty scoreboard means it is idle;
	// an extra wait after that covers the staging register.
	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		cfg_we    = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Mix of sign extremes, a narrow band around zero (lots of ties) and
	// full-range values.
	function automatic logic [VALUE_WIDTH-1:0] draw_value();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
			2, 3, 4: return VALUE_WIDTH'(int'($urandom_range(0, 16)) - 8);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [1:0] draw_kind(input int unsigned ins_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return KIND_UNUSED;
		if (r < 3 + ins_pct)
			return KIND_INSERT;
		return ($urandom_range(0, 3) == 0) ? KIND_PEEK : KIND_REMOVE;
	endfunction

	// Zero, one, built depth, above depth (saturates), and in between.
	function automatic logic [CAP_W-1:0] draw_capacity();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CAP_W'(1);
			2: return CAP_W'(DEPTH);
			3: return '1;
			4: return CAP_W'(2);
			5: return CAP_W'($urandom_range(DEPTH + 1, 127));
			default: return CAP_W'($urandom_range(1, DEPTH));
		endcase
	endfunction

	initial begin
		int unsigned ins_pct;
		int unsigned burst;
		cfg_we       = 1'b0;
		cfg_wdata    = CAP_RESET;
		req_ch.valid = 1'b0;
		req_ch.kind  = KIND_INSERT;
		req_ch.value = '0;
		idle_en      = 1'b1;
		n_sent       = 0;
		@(posedge arst_n);
		@(negedge clk);

		// --- directed, reset capacity ---
		// remove/peek on an empty queue, and the no-op kind
		send(KIND_PEEK, 32'h1234_5678);
		send(KIND_REMOVE, 32'hFFFF_FFFF);
		send(KIND_UNUSED, 32'hFFFF_FFFF);
		// sign extremes, zero, minus one, ties
		send(KIND_INSERT, 32'h7FFF_FFFF);
		send(KIND_INSERT, 32'h8000_0000);
		send(KIND_INSERT, 32'h0000_0000);
		send(KIND_INSERT, 32'hFFFF_FFFF);
		send(KIND_INSERT, 32'd5);
		send(KIND_INSERT, 32'd5);
		send(KIND_INSERT, 32'd1);
		send(KIND_PEEK, 32'h0);
		send(KIND_UNUSED, 32'hA5A5_A5A5);
		repeat (4) send(KIND_REMOVE, 32'h0);

		// capacity dropped below the count: inserts refused until it falls
		set_capacity(CAP_W'(2));
		send(KIND_INSERT, 32'd7);
		send(KIND_REMOVE, 32'h0);
		send(KIND_INSERT, 32'd7);
		send(KIND_REMOVE, 32'h0);
		send(KIND_INSERT, 32'hFFFF_FFF0);

		// capacity zero refuses every insert
		set_capacity('0);
		send(KIND_INSERT, 32'd3);

		// capacity one: drain, then one fits and the next is full
		set_capacity(CAP_W'(1));
		repeat (3) send(KIND_REMOVE, 32'h0);
		send(KIND_INSERT, 32'd9);
		send(KIND_INSERT, 32'd8);
		send(KIND_PEEK, 32'h0);

		// --- random ---
		// above-depth capacity saturates: fill past the built depth
		set_capacity('1);
		repeat (DEPTH + 3) send(KIND_INSERT, draw_value());
		send(KIND_PEEK, draw_value());

		while (n_sent < ITEMS) begin
			set_capacity(draw_capacity());
			idle_en = (n_sent + 120 < ITEMS) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 2))
				0: ins_pct = 75;
				1: ins_pct = 45;
				default: ins_pct = 15;
			endcase
			burst = $urandom_range(30, 90);
			repeat (burst) begin
				// no idling at all over the last stretch
				if (n_sent + 120 >= ITEMS)
					idle_en = 1'b0;
				send(draw_kind(ins_pct), draw_value());
			end
		end

		wait_drained();
		repeat (2 * DEPTH) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sorted_array_priority_queue.f]
+incdir+src
src/sapq_pkg.sv
src/sapq_if.sv
src/sapq_ram.sv
src/sapq_cmp.sv
src/sorted_array_priority_queue.sv
src/sapq_chk.sv
tb/pq_check.sv
tb/tb_top.sv
